// ===== hw/rtl/xrg_pkg.sv =====
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types, constants and the xorshift step of the random generator.
// ----------------------------------------------------------------------------
package xrg_pkg;

  localparam int unsigned DataW = 64;

  localparam logic [DataW-1:0] DefaultSeed = 64'd88172645463325252;

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 7;
  localparam int unsigned ShiftC = 17;

  typedef enum logic [1:0] {
    REQ_SEED  = 2'd0,
    REQ_NEXT  = 2'd1,
    REQ_RANGE = 2'd2,
    REQ_DICE  = 2'd3
  } req_type_e;

  typedef logic [DataW-1:0] word_t;

  function automatic word_t xorshift_step(input word_t x);
    word_t a;
    word_t b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

// ===== hw/rtl/xrg_if.sv =====
// ----------------------------------------------------------------------------
// xrg_req_if / xrg_rsp_if
// Valid/ready channels for requests into and results out of the generator.
// ----------------------------------------------------------------------------
interface xrg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] seed_value;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic [7:0]  dice_count;
  logic [31:0] dice_sides;

  modport source (
    output valid, req_type, seed_value, range_low, range_high, dice_count, dice_sides,
    input  ready
  );
  modport sink (
    input  valid, req_type, seed_value, range_low, range_high, dice_count, dice_sides,
    output ready
  );
endinterface

interface xrg_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

// ===== hw/rtl/xrg_mod_serial.sv =====
// ----------------------------------------------------------------------------
// xrg_mod_serial
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module xrg_mod_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  xrg_pkg::word_t      dividend_i,
  input  xrg_pkg::word_t      divisor_i,
  output logic                done_o,
  output xrg_pkg::word_t      rem_o
);
  import xrg_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  word_t           dvd_q;
  word_t           dvs_q;
  word_t           rem_q;

  logic [DataW:0]  shifted;
  logic            fits;
  word_t           rem_d;

  always_comb begin
    shifted = {rem_q, dvd_q[DataW-1]};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? DataW'(shifted - {1'b0, dvs_q}) : shifted[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/xorshift_random_generator.sv =====
// ----------------------------------------------------------------------------
// xorshift_random_generator
// 64-bit xorshift generator (13, 7, 17) with raw, ranged and dice requests.
// ----------------------------------------------------------------------------
// Requests arrive on req_i and results leave on rsp_o, both valid/ready.
// A seed transaction loads the state and produces no result; a zero seed
// loads the default constant, and a draw from a zero state steps from it.
// A raw draw passes through StDraw and StDone into the output register.
// In a ranged draw the remainder by the span comes from a bit-serial unit
// that resolves one bit per cycle. A dice request with a zero count returns
// zero; the count saturates at MAX_DICE.
// When the span or the number of sides is zero the draw is used unreduced,
// without the bit-serial unit.
// One request is worked on at a time; req_i.ready is high only while idle.
// The result sits in an output register, so a new request is taken while a
// result waits; a finished result then holds until the register is free.
// Reset clears the generator state to zero and empties the output register.
// ----------------------------------------------------------------------------
module xorshift_random_generator #(
  parameter int unsigned MAX_DICE = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  xrg_req_if.sink   req_i,
  xrg_rsp_if.source rsp_o
);
  import xrg_pkg::*;

  localparam int unsigned MaxCount = (MAX_DICE < 255) ? MAX_DICE : 255;
  localparam int unsigned CntW     = $clog2(MaxCount + 1);

  typedef enum logic [1:0] {
    StIdle,
    StDraw,
    StDiv,
    StDone
  } state_e;

  state_e          state_q, state_d;
  req_type_e       kind_q, kind_d;
  logic [CntW-1:0] count_q, count_d;
  word_t           rng_q, rng_d;
  word_t           lo_q, lo_d;
  word_t           span_q, span_d;
  word_t           acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  word_t           out_value_q, out_value_d;

  logic            div_start;
  logic            div_done;
  word_t           div_rem;
  word_t           draw;
  req_type_e       req_kind;

  xrg_mod_serial u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (draw),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign draw     = xorshift_step((rng_q == '0) ? DefaultSeed : rng_q);
  assign req_kind = req_type_e'(req_i.req_type);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    count_d     = count_q;
    rng_d       = rng_q;
    lo_d        = lo_q;
    span_d      = span_q;
    acc_d       = acc_q;
    out_value_d = out_value_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    div_start   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          kind_d = req_kind;
          acc_d  = '0;
          unique case (req_kind)
            REQ_SEED: begin
              rng_d = (req_i.seed_value == '0) ? DefaultSeed : req_i.seed_value;
            end
            REQ_NEXT: begin
              state_d = StDraw;
            end
            REQ_RANGE: begin
              lo_d    = req_i.range_low;
              span_d  = req_i.range_high - req_i.range_low + 64'd1;
              count_d = CntW'(1);
              state_d = StDraw;
            end
            REQ_DICE: begin
              lo_d   = 64'd1;
              span_d = {32'd0, req_i.dice_sides};
              if (32'(req_i.dice_count) > MaxCount) begin
                count_d = CntW'(MaxCount);
              end else begin
                count_d = CntW'(req_i.dice_count);
              end
              state_d = (req_i.dice_count == '0) ? StDone : StDraw;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StDraw: begin
        rng_d = draw;
        if (kind_q == REQ_NEXT) begin
          acc_d   = draw;
          state_d = StDone;
        end else if (span_q == '0) begin
          acc_d   = acc_q + lo_q + draw;
          count_d = count_q - 1'b1;
          state_d = (count_q == CntW'(1)) ? StDone : StDraw;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          acc_d   = acc_q + lo_q + div_rem;
          count_d = count_q - 1'b1;
          state_d = (count_q == CntW'(1)) ? StDone : StDraw;
        end
      end
      StDone: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = acc_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      kind_q      <= REQ_SEED;
      count_q     <= '0;
      rng_q       <= '0;
      lo_q        <= '0;
      span_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      count_q     <= count_d;
      rng_q       <= rng_d;
      lo_q        <= lo_d;
      span_q      <= span_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      out_value_q <= out_value_d;
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.value = out_value_q;

endmodule

// ===== hw/rtl/xrg_checker.sv =====
// ----------------------------------------------------------------------------
// xrg_checker
// Port-level assertions for the random generator, bound to the top level.
// ----------------------------------------------------------------------------
module xrg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_type_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [63:0] rsp_value_i
);
  import xrg_pkg::*;

  logic req_fire;

  assign req_fire = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i))
    else $error("Stalled result was dropped or changed.");

  a_seed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_type_i == REQ_SEED) |=> req_ready_i)
    else $error("Seed transaction did not leave the block idle.");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_type_i != REQ_SEED) |=> !req_ready_i)
    else $error("Block accepted a request while a draw was in progress.");

  a_raw_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_type_i == REQ_NEXT) && !rsp_valid_i |=> ##2 rsp_valid_i)
    else $error("Raw draw result did not appear on time.");

endmodule

bind xorshift_random_generator xrg_checker u_xrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.value)
);

// ===== bench/xrg_result_checker.sv =====
// ----------------------------------------------------------------------------
// xrg_result_checker
// Watches both channels of the random generator and predicts each result from
// its own copy of the xorshift state, then compares every result transaction
// in order and counts mismatches, unexpected results and outstanding values.
// ----------------------------------------------------------------------------
module xrg_result_checker #(
  parameter int unsigned MaxDice = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  xrg_req_if   req_mon,
  xrg_rsp_if   rsp_mon,
  output int   mismatch_count_o,
  output int   outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import xrg_pkg::*;

  localparam int MaxReported = 10;

  word_t       gen_state;
  word_t       expected_values[$];
  word_t       want;
  word_t       dice_sum;
  int unsigned dice_left;

  function automatic word_t draw_next();
    word_t x;
    x = (gen_state == '0) ? DefaultSeed : gen_state;
    x = x ^ (x << ShiftA);
    x = x ^ (x >> ShiftB);
    x = x ^ (x << ShiftC);
    gen_state = x;
    return x;
  endfunction

  function automatic word_t draw_in_range(input word_t lo, input word_t hi);
    word_t span;
    word_t d;
    span = hi - lo + 64'd1;
    d = draw_next();
    if (span == '0) begin
      return lo + d;
    end
    return lo + (d % span);
  endfunction

  function automatic void note_failure(input string what, input word_t exp_v,
                                       input word_t got_v);
    if (mismatch_count_o < MaxReported) begin
      $display("%t: %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    end
    mismatch_count_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_state = '0;
      expected_values.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_values.size() == 0) begin
          note_failure("result with no request outstanding", '0, rsp_mon.value);
        end else begin
          want = expected_values.pop_front();
          if (rsp_mon.value !== want) begin
            note_failure("value mismatch", want, rsp_mon.value);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        case (req_type_e'(req_mon.req_type))
          REQ_SEED: begin
            gen_state = (req_mon.seed_value == '0) ? DefaultSeed : req_mon.seed_value;
          end
          REQ_NEXT: begin
            expected_values.push_back(draw_next());
          end
          REQ_RANGE: begin
            expected_values.push_back(draw_in_range(req_mon.range_low,
                                                    req_mon.range_high));
          end
          default: begin
            dice_left = req_mon.dice_count;
            if (dice_left > MaxDice) begin
              dice_left = MaxDice;
            end
            dice_sum = '0;
            for (int unsigned i = 0; i < dice_left; i++) begin
              dice_sum += draw_in_range(64'd1, {32'd0, req_mon.dice_sides});
            end
            expected_values.push_back(dice_sum);
          end
        endcase
      end
      outstanding_o = expected_values.size();
    end
  end

endmodule

// ===== bench/xorshift_random_generator_test.sv =====
// ----------------------------------------------------------------------------
// xorshift_random_generator_test
// Drives seed, raw, ranged and dice requests into the generator with random
// idling on both channels, a long result hold-off and a full drain, and
// reports the verdict from the failure and outstanding counts of the result checker.
// ----------------------------------------------------------------------------
module xorshift_random_generator_test;

  timeunit 1ns;
  timeprecision 1ps;

  import xrg_pkg::*;

  localparam int RandomItems   = 830;
  localparam int RspHoldCycles = 400;
  localparam int IdlePercent   = 13;
  localparam int SettleCycles  = 100;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   outstanding;
  bit   steady_mode;
  bit   rsp_hold;

  xrg_req_if req_if ();
  xrg_rsp_if rsp_if ();

  xorshift_random_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  xrg_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_request(input req_type_e kind, input word_t seed,
                              input word_t lo, input word_t hi,
                              input logic [7:0] count, input logic [31:0] sides);
    @(negedge clk_i);
    while (!steady_mode && $urandom_range(99) < IdlePercent) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.req_type   = kind;
    req_if.seed_value = seed;
    req_if.range_low  = lo;
    req_if.range_high = hi;
    req_if.dice_count = count;
    req_if.dice_sides = sides;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
  endtask

  task automatic send_raw();
    send_request(REQ_NEXT, rand_word(), rand_word(), rand_word(), 8'($urandom),
                 $urandom());
  endtask

  task automatic send_range(input word_t lo, input word_t hi);
    send_request(REQ_RANGE, rand_word(), lo, hi, 8'($urandom), $urandom());
  endtask

  task automatic send_dice(input logic [7:0] count, input logic [31:0] sides);
    send_request(REQ_DICE, rand_word(), rand_word(), rand_word(), count, sides);
  endtask

  task automatic send_seed(input word_t seed);
    send_request(REQ_SEED, seed, rand_word(), rand_word(), 8'($urandom), $urandom());
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (outstanding != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic send_random_request();
    int    pick;
    word_t lo;
    word_t hi;
    logic [7:0]  count;
    logic [31:0] sides;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_seed(($urandom_range(4) == 0) ? word_t'(0) : rand_word());
    end else if (pick < 40) begin
      send_raw();
    end else if (pick < 75) begin
      lo = rand_word();
      hi = rand_word();
      case ($urandom_range(9))
        4, 5, 6: hi = lo + word_t'($urandom_range(1000));
        7:       hi = lo - 64'd1;
        8: begin
          lo = word_t'($urandom_range(50));
          hi = word_t'($urandom_range(50));
        end
        9:       lo = '0;
        default: ;
      endcase
      send_range(lo, hi);
    end else begin
      count = ($urandom_range(149) == 0) ? 8'($urandom_range(255))
                                         : 8'($urandom_range(6));
      case ($urandom_range(9))
        0:       sides = '0;
        1:       sides = $urandom();
        2:       sides = 32'hFFFF_FFFF;
        default: sides = 32'($urandom_range(20, 1));
      endcase
      send_dice(count, sides);
    end
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (rsp_hold) begin
        rsp_if.ready = 1'b0;
        repeat (RspHoldCycles) @(negedge clk_i);
        rsp_hold = 1'b0;
      end
      rsp_if.ready = steady_mode || ($urandom_range(99) >= IdlePercent);
    end
  end

  initial begin
    steady_mode       = 1'b0;
    rsp_hold          = 1'b0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_SEED;
    req_if.seed_value = '0;
    req_if.range_low  = '0;
    req_if.range_high = '0;
    req_if.dice_count = '0;
    req_if.dice_sides = '0;
    rsp_if.ready      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The first draw after reset starts from a zero state.
    send_raw();
    send_range('0, '1);
    send_range(64'd5, 64'd4);
    send_range(64'd10, 64'd20);
    send_range('1, '1);
    send_range(64'd100, 64'd3);
    send_range('0, '0);
    send_seed('0);
    send_raw();
    send_seed('1);
    send_raw();
    send_seed(64'h0123_4567_89AB_CDEF);
    send_dice(8'd0, 32'd6);
    send_dice(8'd1, 32'd0);
    send_dice(8'd3, 32'd0);
    send_dice(8'd255, 32'd6);
    send_dice(8'd255, 32'd0);
    send_dice(8'd4, 32'hFFFF_FFFF);
    send_dice(8'd2, 32'd1);
    send_dice(8'd128, 32'd2);
    send_raw();

    for (int i = 0; i < RandomItems; i++) begin
      steady_mode = (i >= 300) && (i < 450);
      if (i == 500) begin
        rsp_hold = 1'b1;
        repeat (12) send_raw();
      end
      if (i == 650) begin
        wait_drained();
      end
      send_random_request();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/xrg_pkg.sv
hw/rtl/xrg_if.sv
hw/rtl/xrg_mod_serial.sv
hw/rtl/xorshift_random_generator.sv
hw/rtl/xrg_checker.sv
bench/xrg_result_checker.sv
bench/xorshift_random_generator_test.sv
